[hw/rtl/csv_ndjson_record_chunker_core_macros.svh]
// Assertion macros shared by the record chunker RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef CSV_NDJSON_RECORD_CHUNKER_CORE_MACROS_SVH
`define CSV_NDJSON_RECORD_CHUNKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CNRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define CNRC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CNRC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CNRC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/cnrc_pkg.sv]
// Package for the CSV/NDJSON record chunker: types, codes and widths.
// No dependencies.
`timescale 1ns / 1ps

package cnrc_pkg;

   localparam int BYTE_CNT_W  = 40;
   localparam int REC_CNT_W   = 32;
   localparam int CHUNK_IDX_W = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 40;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CSV_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LIMIT = 2'd2;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_NUL,
      CLS_NEWLINE,
      CLS_COMMA,
      CLS_QUOTE,
      CLS_CR
   } cnrc_class_type;

   typedef enum logic [1:0] {
      QS_START,
      QS_UNQUOTED,
      QS_QUOTED,
      QS_AFTERQ
   } cnrc_quote_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_NUL,
      ERR_TOO_LONG,
      ERR_BAD_AFTER_QUOTE,
      ERR_UNTERM_RECORD,
      ERR_UNTERM_QUOTE
   } cnrc_error_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           end_of_stream;
      cnrc_class_type cls;
   } cnrc_entry_type;

   function automatic cnrc_class_type classify(input logic [7:0] b);
      cnrc_class_type c;
      unique case (b)
         CHAR_NUL:     c = CLS_NUL;
         CHAR_NEWLINE: c = CLS_NEWLINE;
         CHAR_CR:      c = CLS_CR;
         CHAR_QUOTE:   c = CLS_QUOTE;
         CHAR_COMMA:   c = CLS_COMMA;
         default:      c = CLS_OTHER;
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/cnrc_channels_if.sv]
// Channel interfaces of the record chunker: byte input, tagged result, register writes.
// Depends on cnrc_pkg.
`timescale 1ns / 1ps

interface cnrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface cnrc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [7:0]                         out_byte;
   logic                               byte_valid;
   logic [cnrc_pkg::CHUNK_IDX_W-1:0]   chunk_number;
   logic                               record_end;
   logic                               chunk_end;
   logic [2:0]                         error_code;
   logic                               stream_done;

   modport source (output valid, output out_byte, output byte_valid, output chunk_number,
                   output record_end, output chunk_end, output error_code,
                   output stream_done, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input chunk_number,
                   input record_end, input chunk_end, input error_code,
                   input stream_done, output ready);
endinterface

interface cnrc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [cnrc_pkg::CSR_IDX_W-1:0]    index;
   logic [cnrc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/cnrc_front.sv]
// Front stage of the record chunker: accepts input bytes and tags their character class.
// Depends on cnrc_pkg and cnrc_req_if.
`timescale 1ns / 1ps

module cnrc_front (
   input  logic                     clock,
   input  logic                     reset,
   cnrc_req_if.sink                 req_ch,
   output logic                     q_valid,
   input  logic                     q_ready,
   output cnrc_pkg::cnrc_entry_type q_entry
);

   logic                     valid_ff;
   cnrc_pkg::cnrc_entry_type entry_ff;
   cnrc_pkg::cnrc_entry_type entry_in;

   // Stage is free when empty or when the queue takes its entry this cycle.
   assign req_ch.ready = !valid_ff || q_ready;
   assign q_valid      = valid_ff;
   assign q_entry      = entry_ff;

   always_comb begin
      entry_in.data_byte     = req_ch.data_byte;
      entry_in.end_of_stream = req_ch.end_of_stream;
      entry_in.cls           = cnrc_pkg::classify(req_ch.data_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         entry_ff <= entry_in;
      end
   end

endmodule

[hw/rtl/cnrc_queue.sv]
// Small queue between the front and back stages of the record chunker.
// Depends on cnrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "csv_ndjson_record_chunker_core_macros.svh"

module cnrc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  cnrc_pkg::cnrc_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output cnrc_pkg::cnrc_entry_type pop_entry
);

   cnrc_pkg::cnrc_entry_type              mem_ff [cnrc_pkg::QUEUE_DEPTH];
   logic [cnrc_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff;
   logic [cnrc_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff;
   logic [cnrc_pkg::QUEUE_CNT_W-1:0]      count_ff;
   logic                                  push;
   logic                                  pop;

   assign push_ready = (count_ff != cnrc_pkg::QUEUE_CNT_W'(cnrc_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CNRC_ASSERT_IMP(a_queue_count_bound, clock, reset, 1'b1, count_ff <= cnrc_pkg::QUEUE_CNT_W'(cnrc_pkg::QUEUE_DEPTH), "queue count above depth")
   `CNRC_ASSERT_IMP(a_queue_ptr_match, clock, reset, 1'b1, count_ff[cnrc_pkg::QUEUE_PTR_W-1:0] == cnrc_pkg::QUEUE_PTR_W'(wr_ptr_ff - rd_ptr_ff), "queue pointers disagree with count")

endmodule

[hw/rtl/cnrc_back.sv]
// Back stage of the record chunker: quote tracking, counters, split decision, result register.
// Depends on cnrc_pkg, cnrc_csr_if, cnrc_rsp_if and the assertion macro header.
`timescale 1ns / 1ps
`include "csv_ndjson_record_chunker_core_macros.svh"

module cnrc_back #(
   parameter int MAX_RECORD_BYTES = 16777216
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  cnrc_pkg::cnrc_entry_type in_entry,
   cnrc_csr_if.sink                 csr_ch,
   cnrc_rsp_if.source               rsp_ch
);

   localparam int REC_LEN_W = $clog2(MAX_RECORD_BYTES + 1);
   localparam int BCW = cnrc_pkg::BYTE_CNT_W;
   localparam int RCW = cnrc_pkg::REC_CNT_W;
   localparam int CIW = cnrc_pkg::CHUNK_IDX_W;

   // configuration
   logic                          csv_mode_ff;
   logic [BCW-1:0]                byte_limit_ff;
   logic [RCW-1:0]                record_limit_ff;

   // stream state
   cnrc_pkg::cnrc_quote_type      quote_ff, quote_in;
   logic [REC_LEN_W-1:0]          rec_len_ff, rec_len_in;
   logic [BCW-1:0]                byte_cnt_ff, byte_cnt_in, byte_cnt_inc;
   logic [RCW-1:0]                rec_cnt_ff, rec_cnt_in, rec_cnt_inc;
   logic [CIW-1:0]                chunk_idx_ff, chunk_idx_in, chunk_idx_inc;
   logic                          open_ff, open_in;
   logic                          seen_ff, seen_in;
   cnrc_pkg::cnrc_error_type      sticky_ff, sticky_in;

   logic                          out_valid_ff;
   logic                          take;
   cnrc_pkg::cnrc_error_type      err;
   logic                          byte_ok, rec_end, ch_end, boundary, split;

   assign csr_ch.ready = 1'b1;
   assign in_ready     = !out_valid_ff || rsp_ch.ready;
   assign take         = in_valid && in_ready;
   assign rsp_ch.valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csv_mode_ff     <= 1'b0;
         byte_limit_ff   <= '0;
         record_limit_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            cnrc_pkg::CSR_CSV_MODE:     csv_mode_ff     <= csr_ch.data[0];
            cnrc_pkg::CSR_BYTE_LIMIT:   byte_limit_ff   <= csr_ch.data[BCW-1:0];
            cnrc_pkg::CSR_RECORD_LIMIT: record_limit_ff <= csr_ch.data[RCW-1:0];
            default: ;
         endcase
      end
   end

   // Saturating increments.
   assign byte_cnt_inc  = (byte_cnt_ff == '1) ? byte_cnt_ff : byte_cnt_ff + 1'b1;
   assign rec_cnt_inc   = (rec_cnt_ff == '1) ? rec_cnt_ff : rec_cnt_ff + 1'b1;
   assign chunk_idx_inc = (chunk_idx_ff == '1) ? chunk_idx_ff : chunk_idx_ff + 1'b1;

   always_comb begin
      quote_in     = quote_ff;
      rec_len_in   = rec_len_ff;
      byte_cnt_in  = byte_cnt_ff;
      rec_cnt_in   = rec_cnt_ff;
      chunk_idx_in = chunk_idx_ff;
      open_in      = open_ff;
      seen_in      = seen_ff;
      err          = cnrc_pkg::ERR_NONE;
      byte_ok      = 1'b0;
      rec_end      = 1'b0;
      ch_end       = 1'b0;
      boundary     = 1'b0;
      split        = 1'b0;

      if (sticky_ff != cnrc_pkg::ERR_NONE) begin
         err = sticky_ff;
      end else if (in_entry.end_of_stream) begin
         if (seen_ff) begin
            if (!csv_mode_ff && rec_len_ff != '0) begin
               err = cnrc_pkg::ERR_UNTERM_RECORD;
            end else if (csv_mode_ff && quote_ff == cnrc_pkg::QS_QUOTED) begin
               err = cnrc_pkg::ERR_UNTERM_QUOTE;
            end else begin
               if (open_ff) begin
                  ch_end       = 1'b1;
                  chunk_idx_in = chunk_idx_inc;
               end
               byte_cnt_in = '0;
               rec_cnt_in  = '0;
               open_in     = 1'b0;
               quote_in    = cnrc_pkg::QS_START;
               rec_len_in  = '0;
               seen_in     = 1'b0;
            end
         end
      end else if (in_entry.cls == cnrc_pkg::CLS_NUL) begin
         err = cnrc_pkg::ERR_NUL;
      end else if (rec_len_ff >= REC_LEN_W'(MAX_RECORD_BYTES)) begin
         err = cnrc_pkg::ERR_TOO_LONG;
      end else begin
         if (!csv_mode_ff) begin
            boundary = (in_entry.cls == cnrc_pkg::CLS_NEWLINE);
         end else begin
            unique case (quote_ff)
               cnrc_pkg::QS_START: begin
                  unique case (in_entry.cls) inside
                     cnrc_pkg::CLS_QUOTE:                  quote_in = cnrc_pkg::QS_QUOTED;
                     cnrc_pkg::CLS_NEWLINE:                boundary = 1'b1;
                     cnrc_pkg::CLS_COMMA, cnrc_pkg::CLS_CR: quote_in = cnrc_pkg::QS_START;
                     default:                              quote_in = cnrc_pkg::QS_UNQUOTED;
                  endcase
               end
               cnrc_pkg::QS_UNQUOTED: begin
                  unique case (in_entry.cls)
                     cnrc_pkg::CLS_COMMA: quote_in = cnrc_pkg::QS_START;
                     cnrc_pkg::CLS_NEWLINE: begin
                        boundary = 1'b1;
                        quote_in = cnrc_pkg::QS_START;
                     end
                     default: ;
                  endcase
               end
               cnrc_pkg::QS_QUOTED: begin
                  if (in_entry.cls == cnrc_pkg::CLS_QUOTE) begin
                     quote_in = cnrc_pkg::QS_AFTERQ;
                  end
               end
               default: begin
                  // after a closing quote only a quote, separator, carriage return or line end may follow
                  unique case (in_entry.cls)
                     cnrc_pkg::CLS_QUOTE: quote_in = cnrc_pkg::QS_QUOTED;
                     cnrc_pkg::CLS_COMMA: quote_in = cnrc_pkg::QS_START;
                     cnrc_pkg::CLS_NEWLINE: begin
                        boundary = 1'b1;
                        quote_in = cnrc_pkg::QS_START;
                     end
                     cnrc_pkg::CLS_CR: ;
                     default: err = cnrc_pkg::ERR_BAD_AFTER_QUOTE;
                  endcase
               end
            endcase
         end

         if (err == cnrc_pkg::ERR_NONE) begin
            byte_ok     = 1'b1;
            seen_in     = 1'b1;
            open_in     = 1'b1;
            rec_len_in  = rec_len_ff + 1'b1;
            byte_cnt_in = byte_cnt_inc;
            if (boundary) begin
               rec_end    = 1'b1;
               rec_len_in = '0;
               rec_cnt_in = rec_cnt_inc;
               if (byte_limit_ff != '0 && byte_cnt_inc >= byte_limit_ff) begin
                  split = 1'b1;
               end
               if (record_limit_ff != '0) begin
                  // CSV header stays with the first record of the first chunk
                  if (csv_mode_ff && record_limit_ff == RCW'(1) && chunk_idx_ff == CIW'(1)) begin
                     if (rec_cnt_inc > RCW'(1)) begin
                        split = 1'b1;
                     end
                  end else if (rec_cnt_inc >= record_limit_ff) begin
                     split = 1'b1;
                  end
               end
               if (split) begin
                  ch_end       = 1'b1;
                  chunk_idx_in = chunk_idx_inc;
                  byte_cnt_in  = '0;
                  rec_cnt_in   = '0;
                  open_in      = 1'b0;
               end
            end
         end else begin
            quote_in = quote_ff;
         end
      end

      sticky_in = (err != cnrc_pkg::ERR_NONE) ? err : sticky_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= cnrc_pkg::QS_START;
      end else if (take) begin
         quote_ff <= quote_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_len_ff   <= '0;
         byte_cnt_ff  <= '0;
         rec_cnt_ff   <= '0;
         chunk_idx_ff <= CIW'(1);
         open_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         sticky_ff    <= cnrc_pkg::ERR_NONE;
      end else if (take) begin
         rec_len_ff   <= rec_len_in;
         byte_cnt_ff  <= byte_cnt_in;
         rec_cnt_ff   <= rec_cnt_in;
         chunk_idx_ff <= chunk_idx_in;
         open_ff      <= open_in;
         seen_ff      <= seen_in;
         sticky_ff    <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ch.out_byte     <= in_entry.end_of_stream ? 8'h00 : in_entry.data_byte;
         rsp_ch.byte_valid   <= byte_ok;
         rsp_ch.chunk_number <= chunk_idx_ff;
         rsp_ch.record_end   <= rec_end;
         rsp_ch.chunk_end    <= ch_end;
         rsp_ch.error_code   <= err;
         rsp_ch.stream_done  <= in_entry.end_of_stream;
      end
   end

   `CNRC_ASSERT_IMP(a_closed_chunk_empty, clock, reset, !open_ff, (byte_cnt_ff == '0) && (rec_cnt_ff == '0), "counts nonzero with no open chunk")
   `CNRC_ASSERT_IMP(a_record_length_bound, clock, reset, 1'b1, rec_len_ff <= REC_LEN_W'(MAX_RECORD_BYTES), "record length past limit")
   `CNRC_ASSERT_IMP(a_valid_byte_no_error, clock, reset, out_valid_ff && rsp_ch.byte_valid, rsp_ch.error_code == 3'(cnrc_pkg::ERR_NONE), "byte passed with error code")
   `CNRC_ASSERT_IMP(a_record_end_on_byte, clock, reset, out_valid_ff && rsp_ch.record_end, rsp_ch.byte_valid && !rsp_ch.stream_done, "record end without a passed byte")

endmodule

[hw/rtl/csv_ndjson_record_chunker_core.sv]
// Top level of the CSV/NDJSON record chunker.
// Depends on cnrc_pkg, the channel interfaces, cnrc_front, cnrc_queue and cnrc_back.
// Path: a byte passes the front reg, the queue and the result reg before its result is valid.
// Throughput: one byte per cycle unless stalled; result reg and 4-entry queue decouple stalls.
// Reset (synchronous, active high): registers read 0, chunk index 1, no error, queue empty.
// No memory clearing pass; the block takes bytes in the first cycle after reset.
`timescale 1ns / 1ps

module csv_ndjson_record_chunker_core #(
   parameter int MAX_RECORD_BYTES = 16777216
) (
   input  logic        clock,
   input  logic        reset,
   cnrc_req_if.sink    req_ch,
   cnrc_rsp_if.source  rsp_ch,
   cnrc_csr_if.sink    csr_ch
);

   // front stage to queue
   logic                     fq_valid;
   logic                     fq_ready;
   cnrc_pkg::cnrc_entry_type fq_entry;

   // queue to back stage
   logic                     qb_valid;
   logic                     qb_ready;
   cnrc_pkg::cnrc_entry_type qb_entry;

   // Register the byte and tag its character class.
   cnrc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (fq_valid),
      .q_ready (fq_ready),
      .q_entry (fq_entry)
   );

   // Hold classified bytes while the result side stalls.
   cnrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_entry (fq_entry),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_entry  (qb_entry)
   );

   // Advance the quote machine and counters, decide splits, drive the result transfer.
   cnrc_back #(
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (qb_valid),
      .in_ready (qb_ready),
      .in_entry (qb_entry),
      .csr_ch   (csr_ch),
      .rsp_ch   (rsp_ch)
   );

endmodule
